>>> design/bskt_pkg.sv
package bskt_pkg;

	localparam int KEY_W      = 30;
	localparam int TAG_W      = 16;
	localparam int CNT_W      = 6;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 8;
	localparam int DEPTH_DEF  = 32;

	localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

	// request kinds carried in tuser
	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_FIND   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // latch a new request and restart the walk
		logic rd_en;   // read the next table entry
		logic finish;  // commit the request and load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;  // every held entry has been read
	} sts_t;

endpackage

>>> design/bskt_ctrl.sv
module bskt_ctrl
	import bskt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.finish = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// the last read is still processed in the cycle that ends the walk
				if (!sts.scan_done) begin
					cmd.rd_en = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait until the result register is free
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	a_finish_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_done) |=> (state_q == ST_FINISH))
		else $error("walk end did not lead to finish");

	a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (state_q == ST_SCAN && !sts.scan_done))
		else $error("table read outside the walk");

endmodule

>>> design/bskt_dpath.sv
module bskt_dpath
	import bskt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_wdata,
	input  logic [1:0]            in_action,
	input  logic [KEY_W-1:0]      in_key,
	input  logic [TAG_W-1:0]      in_tag,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  res_ok,
	output logic [CNT_W-1:0]      res_count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > CNT_W) ? CW : CNT_W;

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [TAG_W-1:0] tag_mem [DEPTH];

	action_t          act_q;
	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;
	logic [CNT_W-1:0] cap_q;
	logic [CW-1:0]    held_count_q;
	logic [CW-1:0]    rd_idx_q;

	logic             rd_vld_s1;
	logic [IW-1:0]    idx_s1;
	logic [KEY_W-1:0] rd_key_s1;
	logic [TAG_W-1:0] rd_tag_s1;

	logic             found_q, found_d;
	logic             ins_q, ins_d;
	logic             stop_q, stop_d;
	logic             drop_q, drop_d;
	logic [KEY_W-1:0] carry_key_q, carry_key_d;
	logic [TAG_W-1:0] carry_tag_q, carry_tag_d;

	logic             wr_en;
	logic [IW-1:0]    wr_idx;
	logic [KEY_W-1:0] wr_key;
	logic [TAG_W-1:0] wr_tag;

	logic             key_eq, key_ge, full, readd_refused;
	logic             fin_ok;
	logic [CW-1:0]    fin_count;

	logic             res_ok_q;
	logic [CNT_W-1:0] res_count_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action_t'(in_action);
			key_q <= in_key;
			tag_q <= in_tag;
		end
	end

	// walk pointer and read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
		end
	end

	assign sts.scan_done = (rd_idx_q == held_count_q);

	// table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx] <= wr_key;
			tag_mem[wr_idx] <= wr_tag;
		end
		if (cmd.rd_en) begin
			rd_key_s1 <= key_mem[rd_idx_q[IW-1:0]];
			rd_tag_s1 <= tag_mem[rd_idx_q[IW-1:0]];
			idx_s1    <= rd_idx_q[IW-1:0];
		end
	end

	assign key_eq = (rd_key_s1 == key_q);
	assign key_ge = (rd_key_s1 >= key_q);
	assign full   = (MW'(held_count_q) >= MW'(cap_q)) || (held_count_q == CW'(DEPTH));
	// a present key is deleted first; the re-add fails if the table is still at capacity
	assign readd_refused = (MW'(held_count_q - CW'(1)) >= MW'(cap_q));

	// per-entry step of the walk, and the final commit
	always_comb begin
		wr_en       = 1'b0;
		wr_idx      = idx_s1;
		wr_key      = key_q;
		wr_tag      = tag_q;
		found_d     = found_q;
		ins_d       = ins_q;
		stop_d      = stop_q;
		drop_d      = drop_q;
		carry_key_d = carry_key_q;
		carry_tag_d = carry_tag_q;
		fin_ok      = 1'b0;
		fin_count   = held_count_q;
		if (rd_vld_s1) begin
			unique case (act_q)
				ACT_FIND: begin
					if (key_eq) begin
						found_d = 1'b1;
					end
				end
				ACT_REMOVE: begin
					// pull every entry behind the match one slot down
					if (found_q) begin
						wr_en  = 1'b1;
						wr_idx = idx_s1 - IW'(1);
						wr_key = rd_key_s1;
						wr_tag = rd_tag_s1;
					end
					if (key_eq) begin
						found_d = 1'b1;
					end
				end
				ACT_ADD: begin
					if (drop_q) begin
						// close the gap left by the deleted old entry
						wr_en  = 1'b1;
						wr_idx = idx_s1 - IW'(1);
						wr_key = rd_key_s1;
						wr_tag = rd_tag_s1;
					end else if (!stop_q) begin
						if (ins_q) begin
							// ripple the carried entry one slot up
							wr_en       = 1'b1;
							wr_key      = carry_key_q;
							wr_tag      = carry_tag_q;
							carry_key_d = rd_key_s1;
							carry_tag_d = rd_tag_s1;
						end else if (key_ge) begin
							if (key_eq) begin
								if (readd_refused) begin
									// drop the old entry, refuse the add
									found_d = 1'b1;
									drop_d  = 1'b1;
								end else begin
									// same key stays in place with the new tag
									wr_en   = 1'b1;
									found_d = 1'b1;
									stop_d  = 1'b1;
								end
							end else if (full) begin
								stop_d = 1'b1;
							end else begin
								wr_en       = 1'b1;
								carry_key_d = rd_key_s1;
								carry_tag_d = rd_tag_s1;
								ins_d       = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		unique case (act_q)
			ACT_FIND: begin
				fin_ok = found_q;
			end
			ACT_REMOVE: begin
				fin_ok = found_q;
				if (found_q) begin
					fin_count = held_count_q - CW'(1);
				end
			end
			ACT_ADD: begin
				if (drop_q) begin
					fin_count = held_count_q - CW'(1);
				end else if (found_q) begin
					fin_ok = 1'b1;
				end else if (!full) begin
					fin_ok    = 1'b1;
					fin_count = held_count_q + CW'(1);
					// append the last carried entry, or the new one
					if (cmd.finish) begin
						wr_en  = 1'b1;
						wr_idx = held_count_q[IW-1:0];
						if (ins_q) begin
							wr_key = carry_key_q;
							wr_tag = carry_tag_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// walk flags and held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			ins_q        <= 1'b0;
			stop_q       <= 1'b0;
			drop_q       <= 1'b0;
			held_count_q <= '0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
				ins_q   <= 1'b0;
				stop_q  <= 1'b0;
				drop_q  <= 1'b0;
			end else begin
				found_q <= found_d;
				ins_q   <= ins_d;
				stop_q  <= stop_d;
				drop_q  <= drop_d;
			end
			if (cmd.finish) begin
				held_count_q <= fin_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		carry_key_q <= carry_key_d;
		carry_tag_q <= carry_tag_d;
		if (cmd.finish) begin
			res_ok_q    <= fin_ok;
			res_count_q <= CNT_W'(fin_count);
		end
	end

	assign res_ok    = res_ok_q;
	assign res_count = res_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CW'(DEPTH))
		else $error("held count above table depth");

	a_read_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(idx_s1) < held_count_q))
		else $error("read of an entry beyond the held count");

	a_refused_add_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && act_q == ACT_ADD && !found_q && full)
		|=> (held_count_q == $past(held_count_q)))
		else $error("refused add changed the held count");

	a_remove_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && act_q == ACT_REMOVE && found_q)
		|=> (held_count_q == $past(held_count_q) - CW'(1)))
		else $error("remove did not drop exactly one entry");

endmodule

>>> design/bounded_sorted_key_table.sv
// Requests are handled one at a time: a new request beat is taken only in idle, after the
// previous commit. The walk reads one table entry per cycle through the single read port
// of the key and tag memory; the commit waits until the result register is free.
// Reset (arst_n low) clears the held count and sets capacity to 32; the table memory is
// not cleared, since only entries below the held count are ever read.
module bounded_sorted_key_table
	import bskt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_wdata,   // capacity
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,     // key_number[29:0], payload_tag[45:30], zero
	input  logic [1:0]            s_tuser,     // action[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata      // ok[0], entry_count[6:1], zero
);

	cmd_t             cmd;
	sts_t             sts;
	logic             res_ok;
	logic [CNT_W-1:0] res_count;

	bskt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bskt_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_action (s_tuser),
		.in_key    (s_tdata[KEY_W-1:0]),
		.in_tag    (s_tdata[KEY_W+TAG_W-1:KEY_W]),
		.cmd       (cmd),
		.sts       (sts),
		.res_ok    (res_ok),
		.res_count (res_count)
	);

	// pack the result beat
	assign m_tdata = {1'b0, res_count, res_ok};

endmodule
